// File: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared transaction types and field widths for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned SixW  = 6;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             text_end;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           run_last;
  } out_item_t;

  // Work for one input byte: up to two held continuations, then an optional tail value.
  typedef struct packed {
    logic [1:0]      held_n;
    logic [SixW-1:0] held0;
    logic [SixW-1:0] held1;
    logic            has_tail;
    logic [CpW-1:0]  tail;
  } cmd_t;

endpackage : utf8d_pkg
`default_nettype wire

// File: hdl/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted byte's command is queued, then its results are loaded into the output register.
// Throughput: one byte per cycle while the queue has room; a byte causing several results
// holds the single output register until all are taken, while the queue lets input run on.
// A multi-byte lead byte with no open sequence, even at text end, gives no result or push.
// Reset clears the open sequence, empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Front end decodes bytes into commands, a queue decouples it from the back
// end, which delivers code points one transaction at a time.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder import utf8d_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic q_full, q_empty, push, pop;
  cmd_t cmd, head;

  utf8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule : utf8_codepoint_decoder
`default_nettype wire

// File: hdl/utf8d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and issues at most one command per byte.
// ----------------------------------------------------------------------------
module utf8d_front import utf8d_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  logic [2:0]     len_q, len_d;
  logic [1:0]     bt_q, bt_d;
  logic [CpW-1:0] acc_q, acc_d;

  logic [ByteW-1:0] b;
  logic             text_end;
  logic             accept;
  logic             is_cont;
  logic [2:0]       lead_len;
  logic [CpW-1:0]   lead_pay;
  logic [CpW-1:0]   acc_cont;
  logic [1:0]       bt_inc;
  logic             complete;
  cmd_t             cmd;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign b          = in_item_i.byte_in;
  assign text_end   = in_item_i.text_end;
  assign is_cont    = (b[7:6] == 2'b10);
  assign acc_cont   = {acc_q[CpW-SixW-1:0], b[SixW-1:0]};
  assign bt_inc     = bt_q + 2'd1;
  assign complete   = (({1'b0, bt_inc} + 3'd1) >= len_q);

  always_comb begin
    lead_len = 3'd1;
    lead_pay = CpW'(b);
    if (b[7:5] == 3'b110) begin
      lead_len = LenTwo;
      lead_pay = CpW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_len = LenThree;
      lead_pay = CpW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_len = LenFour;
      lead_pay = CpW'(b[2:0]);
    end
  end

  always_comb begin
    len_d = len_q;
    bt_d  = bt_q;
    acc_d = acc_q;
    cmd   = '0;
    if (accept) begin
      if ((len_q != LenNone) && is_cont) begin
        acc_d = acc_cont;
        bt_d  = bt_inc;
        if (complete) begin
          cmd.has_tail = 1'b1;
          cmd.tail     = acc_cont;
          len_d = LenNone;
          bt_d  = '0;
          acc_d = '0;
        end else if (text_end) begin
          cmd.held_n = bt_inc;
          cmd.held0  = (bt_inc == 2'd2) ? acc_cont[2*SixW-1:SixW] : acc_cont[SixW-1:0];
          cmd.held1  = acc_cont[SixW-1:0];
          len_d = LenNone;
          bt_d  = '0;
          acc_d = '0;
        end
      end else begin
        if (len_q != LenNone) begin
          cmd.held_n = bt_q;
          cmd.held0  = (bt_q == 2'd2) ? acc_q[2*SixW-1:SixW] : acc_q[SixW-1:0];
          cmd.held1  = acc_q[SixW-1:0];
        end
        len_d = LenNone;
        bt_d  = '0;
        acc_d = '0;
        if (lead_len == 3'd1) begin
          cmd.has_tail = 1'b1;
          cmd.tail     = CpW'(b);
        end else if (!text_end) begin
          len_d = lead_len;
          acc_d = lead_pay;
        end
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept & ((cmd.held_n != 2'd0) | cmd.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenNone;
      bt_q  <= '0;
      acc_q <= '0;
    end else begin
      len_q <= len_d;
      bt_q  <= bt_d;
      acc_q <= acc_d;
    end
  end

endmodule : utf8d_front
`default_nettype wire

// File: hdl/utf8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder command queue
// Small register FIFO between the front end and the result serializer.
// ----------------------------------------------------------------------------
module utf8d_queue import utf8d_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule : utf8d_queue
`default_nettype wire

// File: hdl/utf8d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands each queued command into one to three results in an output register.
// ----------------------------------------------------------------------------
module utf8d_back import utf8d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  wire cmd_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_item_o
);

  logic [1:0]     idx_q;
  logic           out_valid_q;
  out_item_t      out_q;
  logic [1:0]     total;
  logic           last;
  logic           load;
  logic [CpW-1:0] cp;
  logic [SixW-1:0] six;

  assign total = head_i.held_n + {1'b0, head_i.has_tail};
  assign last  = ((idx_q + 2'd1) == total);
  assign load  = ~empty_i & (~out_valid_q | out_ready_i);
  assign pop_o = load & last;
  assign six   = (idx_q == 2'd0) ? head_i.held0 : head_i.held1;
  assign cp    = (idx_q < head_i.held_n) ? CpW'({2'b10, six}) : head_i.tail;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.code_point <= cp;
      out_q.run_last   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule : utf8d_back
`default_nettype wire

// File: bench/utf8_codepoint_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder regression
// Feeds directed and random byte streams through the decoder under random
// stalls on both channels and checks every code point transaction against a
// cycle-free model of the decoding rules kept alongside the stimulus.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_test;
  import utf8d_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  utf8_codepoint_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  in_item_t       text_q[$];
  logic           drain_q[$];
  out_item_t      code_points_due[$];
  logic [CpW-1:0] burst[$];
  out_item_t      head_due;

  logic [2:0]     open_len = '0;
  logic [1:0]     held_cnt = '0;
  logic [CpW-1:0] gathered = '0;

  int n_bytes = 0;
  int n_points = 0;
  int n_multi = 0;
  int n_silent = 0;
  int n_ends = 0;
  int n_errors = 0;

  wire steady = (n_bytes >= 70) && (n_bytes < 120);

  task automatic flag_error(input string what);
    if (n_errors < 10) begin
      $display("%0t: %s", $time, what);
    end
    n_errors++;
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.byte_in = b;
    it.text_end = last;
    text_q = {text_q, it};
    drain_q = {drain_q, 1'b0};
  endfunction

  // Held continuations come back out as raw bytes, oldest first.
  function automatic void spill_held();
    int sh;
    for (int k = 0; k < held_cnt; k++) begin
      sh = 6 * (held_cnt - 1 - k);
      burst = {burst, CpW'(8'h80 | ((gathered >> sh) & 21'h3F))};
    end
    open_len = '0;
    held_cnt = '0;
    gathered = '0;
  endfunction

  function automatic void decode_byte(input in_item_t it);
    logic [7:0] b;
    logic       grabbed;
    int         len;
    out_item_t  res;
    b = it.byte_in;
    grabbed = 1'b0;
    len = 1;
    burst.delete();
    if (open_len != 0) begin
      if (b[7:6] == 2'b10) begin
        grabbed = 1'b1;
        gathered = {gathered[CpW-7:0], b[5:0]};
        held_cnt = held_cnt + 2'd1;
        if (held_cnt + 1 >= open_len) begin
          burst = {burst, gathered};
          open_len = '0;
          held_cnt = '0;
          gathered = '0;
        end else if (it.text_end) begin
          spill_held();
        end
      end else begin
        spill_held();
      end
    end
    if (!grabbed) begin
      casez (b)
        8'b110?????: begin
          len = 2;
          gathered = CpW'(b[4:0]);
        end
        8'b1110????: begin
          len = 3;
          gathered = CpW'(b[3:0]);
        end
        8'b11110???: begin
          len = 4;
          gathered = CpW'(b[2:0]);
        end
        default: len = 1;
      endcase
      if (len == 1) begin
        burst = {burst, CpW'(b)};
        gathered = '0;
      end else if (!it.text_end) begin
        open_len = 3'(len);
        held_cnt = '0;
      end else begin
        gathered = '0;
      end
    end
    for (int k = 0; k < burst.size(); k++) begin
      res.code_point = burst[k];
      res.run_last = (k == burst.size() - 1);
      code_points_due = {code_points_due, res};
    end
    if (burst.size() == 0) n_silent++;
    if (burst.size() > 1) n_multi++;
    if (it.text_end) n_ends++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_item_i);
        n_bytes++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (text_q.size() != 0 && (steady || $urandom_range(99) >= 13) &&
            !(drain_q[0] && code_points_due.size() != 0)) begin
          in_valid_i <= 1'b1;
          in_item_i <= text_q.pop_front();
          void'(drain_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_points++;
        if (code_points_due.size() == 0) begin
          flag_error($sformatf("unexpected transaction: code point %h last %b",
                               out_item_o.code_point, out_item_o.run_last));
        end else begin
          head_due = code_points_due.pop_front();
          if ((out_item_o.code_point !== head_due.code_point) ||
              (out_item_o.run_last !== head_due.run_last)) begin
            flag_error($sformatf("mismatch: expected code point %h last %b, got %h last %b",
                                 head_due.code_point, head_due.run_last,
                                 out_item_o.code_point, out_item_o.run_last));
          end
        end
      end
      out_ready_i <= steady || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    int          pick;
    int          len;
    int          keep;
    logic        fin;
    logic [7:0]  lead;
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF7, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h41, 1'b1);
    while (text_q.size() < 150) begin
      pick = $urandom_range(99);
      if (pick >= 85) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
        len = $urandom_range(4, 1);
        case (len)
          1: lead = 8'($urandom_range(127));
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        if (pick < 70) begin
          keep = len - 1;
          fin = ($urandom_range(7) == 0);
        end else begin
          keep = (len > 1) ? $urandom_range(len - 2) : 0;
          fin = ($urandom_range(2) == 0);
        end
        queue_byte(lead, (keep == 0) && fin);
        for (int k = 0; k < keep; k++) begin
          queue_byte({2'b10, 6'($urandom)}, (k == keep - 1) && fin);
        end
      end
    end
    drain_q[25] = 1'b1;
    drain_q[110] = 1'b1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (code_points_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes (%0d with text end) and checked %0d code points.",
             n_bytes, n_ends, n_points);
    $display("Bytes giving several code points: %0d, bytes giving none: %0d, errors: %0d.",
             n_multi, n_silent, n_errors);
    if (n_errors == 0) begin
      $display("utf8_codepoint_decoder regression: pass");
    end else begin
      $display("utf8_codepoint_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d code points still due.", code_points_due.size());
    $display("utf8_codepoint_decoder regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/utf8d_pkg.sv
hdl/utf8d_front.sv
hdl/utf8d_queue.sv
hdl/utf8d_back.sv
hdl/utf8_codepoint_decoder.sv
bench/utf8_codepoint_decoder_test.sv
